// ===== src/hslrgb_pkg.sv =====
// Package: shared constants, types and the divide-by-15 helper for the HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none
package hslrgb_pkg;

    localparam int HUE_W           = 15;   // hue field width
    localparam int CFG_W           = 9;    // saturation / lightness width, Q8
    localparam int BYTE_W          = 8;    // channel byte width
    localparam int ONE_Q8          = 256;  // 1.0 in Q8
    localparam int HUE_FRAC_BITS_D = 6;    // default hue fraction bits
    localparam int CFG_IDX_W       = 1;    // two registers

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = 1'b1;

    // Reset values
    localparam logic [CFG_W-1:0] SAT_RST   = 9'd256;
    localparam logic [CFG_W-1:0] LIGHT_RST = 9'd128;

    // Divide by 15 through a reciprocal: exact for operands below 10082.
    localparam int DIV_IN_W    = 13;
    localparam int DIV_OUT_W   = 10;
    localparam int RECIP15     = 8739;  // ceil(2^17 / 15)
    localparam int RECIP15_W   = 14;
    localparam int RECIP_SHIFT = 17;

    // Hue sextant; hues past the last sextant fold onto it.
    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,   // red = C, green = X
        SEXT_YEL_GRN = 3'd1,   // red = X, green = C
        SEXT_GRN_CYN = 3'd2,   // green = C, blue = X
        SEXT_CYN_BLU = 3'd3,   // green = X, blue = C
        SEXT_BLU_MAG = 3'd4,   // red = X, blue = C
        SEXT_MAG_RED = 3'd5    // red = C, blue = X
    } t_sextant;

    // Control group that travels with a hue through the front stages.
    typedef struct packed {
        logic     valid;
        t_sextant sext;
    } t_hue_ctl;

    function automatic logic [DIV_OUT_W-1:0] div15(input logic [DIV_IN_W-1:0] a);
        logic [DIV_IN_W+RECIP15_W-1:0] prod;
        begin
            prod  = {{RECIP15_W{1'b0}}, a} * (DIV_IN_W+RECIP15_W)'(RECIP15);
            div15 = DIV_OUT_W'(prod >> RECIP_SHIFT);
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/hslrgb_hue_split.sv =====
// Hue front end: two-stage sextant index and folded ramp position.
`timescale 1ns / 1ps
`default_nettype none
module hslrgb_hue_split #(
    parameter int HUE_FRAC_BITS = hslrgb_pkg::HUE_FRAC_BITS_D,
    parameter int UNIT          = 60 << HUE_FRAC_BITS,
    parameter int W_W           = $clog2(UNIT + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire  [hslrgb_pkg::HUE_W-1:0] i_hue,
    output hslrgb_pkg::t_hue_ctl         o_ctl,
    output logic [W_W-1:0]               o_ramp
);

    localparam int Q_MAX = ((1 << hslrgb_pkg::HUE_W) - 1) / UNIT;
    localparam int Q_W   = $clog2(Q_MAX + 1);
    localparam logic [hslrgb_pkg::HUE_W-1:0] UNIT_H = hslrgb_pkg::HUE_W'(UNIT);
    localparam logic [W_W-1:0] UNIT_W = W_W'(UNIT);
    localparam logic [hslrgb_pkg::HUE_W-1:0] LAST_Q =
        hslrgb_pkg::HUE_W'(hslrgb_pkg::SEXT_MAG_RED);

    // stage 1: quotient (UNIT = 15 << (frac + 2))
    logic                          r_s1_valid;
    logic [hslrgb_pkg::HUE_W-1:0]  r_s1_hue;
    logic [Q_W-1:0]                r_s1_q;
    logic [Q_W-1:0]                n_s1_q;

    assign n_s1_q = Q_W'(hslrgb_pkg::div15(
        hslrgb_pkg::DIV_IN_W'(i_hue >> (HUE_FRAC_BITS + 2))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_hue <= i_hue;
        r_s1_q   <= n_s1_q;
    end

    // stage 2: remainder, fold on odd sextants, sextant code
    logic [hslrgb_pkg::HUE_W-1:0] q_ext;
    logic [W_W-1:0]               rem;
    logic [W_W-1:0]               n_ramp;
    hslrgb_pkg::t_sextant         n_sext;
    hslrgb_pkg::t_hue_ctl         r_ctl;
    logic [W_W-1:0]               r_ramp;

    always_comb begin
        q_ext  = hslrgb_pkg::HUE_W'(r_s1_q);
        rem    = W_W'(r_s1_hue - q_ext * UNIT_H);
        n_ramp = r_s1_q[0] ? (UNIT_W - rem) : rem;
        if (q_ext > LAST_Q) begin
            n_sext = hslrgb_pkg::SEXT_MAG_RED;
        end else begin
            n_sext = hslrgb_pkg::t_sextant'(3'(r_s1_q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= r_s1_valid;
        end
        r_ctl.sext <= n_sext;
        r_ramp     <= n_ramp;
    end

    assign o_ctl  = r_ctl;
    assign o_ramp = r_ramp;

endmodule
`default_nettype wire

// ===== src/hsl_to_rgb_converter_unit.sv =====
// Top level: pipelined HSL to RGB conversion of one hue per cycle.
// Throughput: one hue per cycle, every cycle; busy is held low.
// Six register stages: quotient, remainder/fold, C*ramp, C*ramp/UNIT, add M, byte scale.
// The receiver cannot stall, so every stage advances every cycle.
// Reset (synchronous, active low) clears the valid bits and loads
// saturation = 1.0 and lightness = 0.5; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module hsl_to_rgb_converter_unit #(
    parameter int HUE_FRAC_BITS = hslrgb_pkg::HUE_FRAC_BITS_D
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // hue transfer
    input  wire                              start,
    output logic                             busy,
    input  wire  [hslrgb_pkg::HUE_W-1:0]     i_hue,
    // result transfer
    output logic                             o_valid,
    output logic [hslrgb_pkg::BYTE_W-1:0]    o_red,
    output logic [hslrgb_pkg::BYTE_W-1:0]    o_green,
    output logic [hslrgb_pkg::BYTE_W-1:0]    o_blue,
    // config write port
    input  wire                              i_cfg_we,
    input  wire  [hslrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [hslrgb_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int UNIT  = 60 << HUE_FRAC_BITS;     // one sextant in hue units
    localparam int W_W   = $clog2(UNIT + 1);        // ramp position, 0..UNIT
    localparam int CW_W  = hslrgb_pkg::CFG_W + W_W; // C * ramp
    localparam int V_W   = hslrgb_pkg::CFG_W + 1;   // component + M
    localparam int SC_W  = V_W + 8;                 // v * 255
    localparam logic [hslrgb_pkg::CFG_W-1:0] ONE = hslrgb_pkg::CFG_W'(hslrgb_pkg::ONE_Q8);

    // no backpressure toward the sender
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------- configuration registers ----------------
    logic [hslrgb_pkg::CFG_W-1:0] r_saturation;
    logic [hslrgb_pkg::CFG_W-1:0] r_lightness;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation <= hslrgb_pkg::SAT_RST;
            r_lightness  <= hslrgb_pkg::LIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hslrgb_pkg::REG_SATURATION: r_saturation <= i_cfg_data;
                hslrgb_pkg::REG_LIGHTNESS:  r_lightness  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Chroma and offset depend only on config; they are recomputed every cycle, the
    // offset registered from the registered chroma, and settle before any new hue needs them.
    logic [hslrgb_pkg::CFG_W-1:0] sat_cl;
    logic [hslrgb_pkg::CFG_W-1:0] light_cl;
    logic [hslrgb_pkg::CFG_W:0]   two_l;
    logic [hslrgb_pkg::CFG_W:0]   l_dev;
    logic [hslrgb_pkg::CFG_W-1:0] tee;
    logic [2*hslrgb_pkg::CFG_W-1:0] ts_prod;
    logic [hslrgb_pkg::CFG_W-1:0] r_chroma;
    logic [hslrgb_pkg::CFG_W-1:0] r_light_q;
    logic [hslrgb_pkg::CFG_W-1:0] r_offset;

    always_comb begin
        sat_cl   = (r_saturation > ONE) ? ONE : r_saturation;
        light_cl = (r_lightness  > ONE) ? ONE : r_lightness;
        two_l    = {light_cl, 1'b0};
        l_dev    = (two_l >= {1'b0, ONE}) ? (two_l - {1'b0, ONE}) : ({1'b0, ONE} - two_l);
        tee      = hslrgb_pkg::CFG_W'({1'b0, ONE} - l_dev);
        ts_prod  = {{hslrgb_pkg::CFG_W{1'b0}}, tee} * {{hslrgb_pkg::CFG_W{1'b0}}, sat_cl};
    end

    always_ff @(posedge i_clk) begin
        r_chroma  <= hslrgb_pkg::CFG_W'(ts_prod >> 8);
        r_light_q <= light_cl;
        // M = L - C/2, never negative since C <= 2L
        r_offset  <= r_light_q - (r_chroma >> 1);
    end

    // ---------------- stages 1-2: sextant and ramp position ----------------
    hslrgb_pkg::t_hue_ctl s2_ctl;
    logic [W_W-1:0]       s2_ramp;

    hslrgb_hue_split #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .UNIT          (UNIT),
        .W_W           (W_W)
    ) u_hue_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_hue   (i_hue),
        .o_ctl   (s2_ctl),
        .o_ramp  (s2_ramp)
    );

    // ---------------- stage 3: C * ramp ----------------
    hslrgb_pkg::t_hue_ctl r_s3_ctl;
    logic [CW_W-1:0]      r_s3_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl.valid <= 1'b0;
        end else begin
            r_s3_ctl.valid <= s2_ctl.valid;
        end
        r_s3_ctl.sext <= s2_ctl.sext;
        r_s3_cw       <= CW_W'(r_chroma) * CW_W'(s2_ramp);
    end

    // ---------------- stage 4: X = (C * ramp) / UNIT ----------------
    // UNIT = 15 << (frac + 2): shift, then reciprocal divide by 15.
    hslrgb_pkg::t_hue_ctl         r_s4_ctl;
    logic [hslrgb_pkg::CFG_W-1:0] r_s4_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl.valid <= 1'b0;
        end else begin
            r_s4_ctl.valid <= r_s3_ctl.valid;
        end
        r_s4_ctl.sext <= r_s3_ctl.sext;
        r_s4_x        <= hslrgb_pkg::CFG_W'(hslrgb_pkg::div15(
            hslrgb_pkg::DIV_IN_W'(r_s3_cw >> (HUE_FRAC_BITS + 2))));
    end

    // ---------------- stage 5: place C / X / 0 and add M ----------------
    logic [hslrgb_pkg::CFG_W-1:0] comp_r;
    logic [hslrgb_pkg::CFG_W-1:0] comp_g;
    logic [hslrgb_pkg::CFG_W-1:0] comp_b;
    logic                         r_s5_valid;
    logic [V_W-1:0]               r_s5_r;
    logic [V_W-1:0]               r_s5_g;
    logic [V_W-1:0]               r_s5_b;

    always_comb begin
        comp_r = '0;
        comp_g = '0;
        comp_b = '0;
        unique case (r_s4_ctl.sext)
            hslrgb_pkg::SEXT_RED_YEL: begin comp_r = r_chroma; comp_g = r_s4_x;   end
            hslrgb_pkg::SEXT_YEL_GRN: begin comp_r = r_s4_x;   comp_g = r_chroma; end
            hslrgb_pkg::SEXT_GRN_CYN: begin comp_g = r_chroma; comp_b = r_s4_x;   end
            hslrgb_pkg::SEXT_CYN_BLU: begin comp_g = r_s4_x;   comp_b = r_chroma; end
            hslrgb_pkg::SEXT_BLU_MAG: begin comp_r = r_s4_x;   comp_b = r_chroma; end
            default:                  begin comp_r = r_chroma; comp_b = r_s4_x;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else begin
            r_s5_valid <= r_s4_ctl.valid;
        end
        r_s5_r <= V_W'(comp_r) + V_W'(r_offset);
        r_s5_g <= V_W'(comp_g) + V_W'(r_offset);
        r_s5_b <= V_W'(comp_b) + V_W'(r_offset);
    end

    // ---------------- stage 6: (v * 255) >> 8, saturate ----------------
    function automatic logic [hslrgb_pkg::BYTE_W-1:0] to_byte(input logic [V_W-1:0] v);
        logic [SC_W-1:0] sc;
        logic [SC_W-9:0] hi;
        begin
            sc = {v, 8'd0} - SC_W'(v);
            hi = sc[SC_W-1:8];
            to_byte = (hi > (SC_W-8)'(255)) ? 8'hFF : hi[hslrgb_pkg::BYTE_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s5_valid;
        end
        o_red   <= to_byte(r_s5_r);
        o_green <= to_byte(r_s5_g);
        o_blue  <= to_byte(r_s5_b);
    end

`ifndef SYNTH
    // every accepted hue yields exactly one strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_valid)
        else $error("result strobe missing for accepted hue");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 6))
        else $error("result strobe without an accepted hue");

    // folded ramp never exceeds one sextant
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_ctl.valid |-> (s2_ramp <= W_W'(UNIT)))
        else $error("ramp position out of range");

    // ramp component never exceeds chroma
    a_x_le_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_ctl.valid |-> (r_s4_x <= r_chroma))
        else $error("ramp component above chroma");
`endif

endmodule
`default_nettype wire
